[design/tcqas_pkg.sv]
`timescale 1ns / 1ps
package tcqas_pkg;
  localparam int QueueDepthDef = 16;
  localparam int IdW = 31;
  localparam int PlW = 64;

  localparam logic [1:0] OP_JOIN = 2'd0;
  localparam logic [1:0] OP_SERVE = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_MOVE = 2'd3;

  localparam logic [2:0] ST_JOINED = 3'd0;
  localparam logic [2:0] ST_SERVED = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;
  localparam logic [2:0] ST_FLUSHED = 3'd5;
  localparam logic [2:0] ST_NOFLUSH = 3'd6;

  typedef struct packed {
    logic [1:0]     operation;
    logic           queue_select;
    logic [IdW-1:0] entry_id;
    logic [PlW-1:0] entry_payload;
  } in_item_t;

  typedef struct packed {
    logic [2:0]     status;
    logic           queue_tag;
    logic [4:0]     position;
    logic [IdW-1:0] result_id;
    logic [PlW-1:0] result_payload;
    logic           last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SRCH_RD, S_SRCH_CMP, S_SHIFT_RD, S_SHIFT_WR,
    S_APPEND, S_FL_RD, S_FL_EMIT, S_OUT
  } state_t;
endpackage

[design/two_class_queue_alternating_server_unit.sv]
`timescale 1ns / 1ps
// One transaction at a time: the input stalls from the accepting edge until the last result
// is taken. Join, empty serve and refused flush answer straight from decode; a successful serve
// or move searches the source queue entry by entry, closes the gap and appends; flush emits one
// result per entry. The single read port of the entry memory makes each read a step of its own.
// Synchronous active-low reset clears counts, turn and served-once flags; the entry
// memory is not cleared.
module two_class_queue_alternating_server_unit
  import tcqas_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // One memory holds both queues; the top address bit selects the queue.
  logic [IdW+PlW-1:0] mem [2*(1<<AW)];
  logic [IdW+PlW-1:0] rd_data_r;

  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  out_item_t res_r, res_nxt;
  logic [CW-1:0] cnt_r [2];
  logic [CW-1:0] cnt_nxt [2];
  logic turn_r, turn_nxt, once_r, once_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic q_r, q_nxt;
  logic [IdW+PlW-1:0] hold_r, hold_nxt;
  logic fin_r, fin_nxt;

  logic rd_en, wr_en;
  logic [AW:0] rd_addr, wr_addr;
  logic [IdW+PlW-1:0] wr_data;

  logic serve_q;
  logic match;
  logic [CW-1:0] sel_cnt, dst_cnt, idx_inc;
  logic dst_full, srch_end, fl_qend, fl_done;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data = res_r;

  assign serve_q = turn_r || (!once_r && cnt_r[0] == '0);
  // A serve always takes the head, so its search matches at once.
  assign match = (item_r.operation == OP_SERVE) ||
                 (rd_data_r[IdW+PlW-1:PlW] == item_r.entry_id);
  assign sel_cnt = cnt_r[item_r.queue_select];
  assign dst_cnt = cnt_r[~q_r];
  assign idx_inc = idx_r + 1'b1;
  assign dst_full = (dst_cnt >= DEPTH_C);
  assign srch_end = (idx_inc >= cnt_r[q_r]);
  assign fl_qend = (idx_inc == cnt_r[q_r]);
  assign fl_done = fl_qend && (q_r || (cnt_r[1] == '0));

  function automatic out_item_t mk(logic [2:0] st, logic tg, logic [4:0] p,
                                   logic [IdW+PlW-1:0] e, logic l);
    out_item_t o;
    o.status = st;
    o.queue_tag = tg;
    o.position = p;
    o.result_id = e[IdW+PlW-1:PlW];
    o.result_payload = e[PlW-1:0];
    o.last = l;
    return o;
  endfunction

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        unique case (item_r.operation)
          OP_JOIN:  state_nxt = S_OUT;
          OP_SERVE: state_nxt = (cnt_r[serve_q] == '0) ? S_OUT : S_SRCH_RD;
          OP_FLUSH: state_nxt = (cnt_r[0] == '0 && cnt_r[1] == '0) ? S_OUT : S_FL_RD;
          OP_MOVE:  state_nxt = (sel_cnt == '0) ? S_OUT : S_SRCH_RD;
        endcase
      end
      S_SRCH_RD:  state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (match) begin
          state_nxt = (item_r.operation == OP_MOVE && dst_full) ? S_OUT : S_SHIFT_RD;
        end else begin
          state_nxt = srch_end ? S_OUT : S_SRCH_RD;
        end
      end
      S_SHIFT_RD: state_nxt = srch_end ? S_APPEND : S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_APPEND:   state_nxt = S_OUT;
      S_FL_RD:    state_nxt = S_FL_EMIT;
      S_FL_EMIT:  state_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall) state_nxt = fin_r ? S_IDLE : S_FL_RD;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    item_nxt = item_r;
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    turn_nxt = turn_r;
    once_nxt = once_r;
    idx_nxt = idx_r;
    q_nxt = q_r;
    hold_nxt = hold_r;
    fin_nxt = fin_r;
    rd_en = 1'b0;
    wr_en = 1'b0;
    rd_addr = {q_r, idx_r[AW-1:0]};
    wr_addr = {q_r, idx_r[AW-1:0]};
    wr_data = rd_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) item_nxt = in_data;
      end
      S_DECODE: begin
        idx_nxt = '0;
        fin_nxt = 1'b1;
        unique case (item_r.operation)
          OP_JOIN: begin
            q_nxt = item_r.queue_select;
            if (sel_cnt >= DEPTH_C) begin
              res_nxt = mk(ST_FULL, item_r.queue_select, 5'd0, '0, 1'b1);
            end else begin
              wr_en = 1'b1;
              wr_addr = {item_r.queue_select, sel_cnt[AW-1:0]};
              wr_data = {item_r.entry_id, item_r.entry_payload};
              cnt_nxt[item_r.queue_select] = sel_cnt + 1'b1;
              res_nxt = mk(ST_JOINED, item_r.queue_select, 5'd0, '0, 1'b1);
            end
          end
          OP_SERVE: begin
            turn_nxt = !serve_q;
            if (serve_q) once_nxt = 1'b1;
            q_nxt = serve_q;
            if (cnt_r[serve_q] == '0) begin
              res_nxt = mk(ST_EMPTY, serve_q, 5'd0, '0, 1'b1);
            end
          end
          OP_FLUSH: begin
            if (cnt_r[0] == '0 && cnt_r[1] == '0) begin
              res_nxt = mk(ST_NOFLUSH, 1'b0, 5'd0, '0, 1'b1);
            end else begin
              q_nxt = (cnt_r[0] == '0);
            end
          end
          OP_MOVE: begin
            q_nxt = item_r.queue_select;
            if (sel_cnt == '0) begin
              res_nxt = mk(ST_NOTFOUND, item_r.queue_select, 5'd0, '0, 1'b1);
            end
          end
        endcase
      end
      S_SRCH_RD: begin
        rd_en = 1'b1;
      end
      S_SRCH_CMP: begin
        if (match) begin
          if (item_r.operation == OP_MOVE && dst_full) begin
            res_nxt = mk(ST_FULL, ~q_r, 5'd0, '0, 1'b1);
          end else begin
            hold_nxt = rd_data_r;
          end
        end else begin
          idx_nxt = idx_inc;
          if (srch_end) res_nxt = mk(ST_NOTFOUND, q_r, 5'd0, '0, 1'b1);
        end
      end
      S_SHIFT_RD: begin
        if (!srch_end) begin
          rd_en = 1'b1;
          rd_addr = {q_r, idx_inc[AW-1:0]};
        end
      end
      S_SHIFT_WR: begin
        wr_en = 1'b1;
        idx_nxt = idx_inc;
      end
      S_APPEND: begin
        cnt_nxt[q_r] = cnt_r[q_r] - 1'b1;
        if (item_r.operation == OP_MOVE) begin
          wr_en = 1'b1;
          wr_addr = {~q_r, dst_cnt[AW-1:0]};
          wr_data = hold_r;
          cnt_nxt[~q_r] = dst_cnt + 1'b1;
          res_nxt = mk(ST_JOINED, ~q_r, 5'd0, hold_r, 1'b1);
        end else begin
          res_nxt = mk(ST_SERVED, q_r, 5'd0, hold_r, 1'b1);
        end
      end
      S_FL_RD: begin
        rd_en = 1'b1;
      end
      S_FL_EMIT: begin
        res_nxt = mk(ST_FLUSHED, q_r, 5'(idx_inc), rd_data_r, fl_done);
        if (fl_qend) begin
          // The current queue is done: clear it; after queue A, carry on with B if it holds anything.
          cnt_nxt[q_r] = '0;
          idx_nxt = '0;
          q_nxt = 1'b1;
          fin_nxt = fl_done;
        end else begin
          idx_nxt = idx_inc;
          fin_nxt = 1'b0;
        end
      end
      S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      turn_r <= 1'b0;
      once_r <= 1'b0;
      fin_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      turn_r <= turn_nxt;
      once_r <= once_nxt;
      fin_r <= fin_nxt;
    end
    item_r <= item_nxt;
    res_r <= res_nxt;
    idx_r <= idx_nxt;
    q_r <= q_nxt;
    hold_r <= hold_nxt;
  end
endmodule
